// ===== design/hfpp_pkg.sv =====
// Package for the hex frame parity parser.
// Holds line geometry, register index codes, the decoded field struct and the
// hex digit helpers. Depends on nothing.
`default_nettype none

package hfpp_pkg;

   // Line geometry: positions held per line and the widths that follow from it.
   localparam int LINE_LENGTH = 16;
   localparam int CNT_W       = $clog2(LINE_LENGTH + 1);
   localparam int IDX_W       = $clog2(LINE_LENGTH);

   // Character that closes a line.
   localparam logic [7:0] LINE_FEED = 8'h0A;

   // Start positions of the hex digit pairs within a line.
   localparam int POS_TYPE    = 1;
   localparam int POS_NODE    = 4;
   localparam int POS_ID      = 7;
   localparam int POS_PAYLOAD = 10;
   localparam int POS_PARITY  = 13;

   // Control register indexes.
   typedef enum logic [2:0] {
      CSR_COMMAND_TYPE      = 3'd0,
      CSR_REPLY_TYPE        = 3'd1,
      CSR_DATA_INT_TYPE     = 3'd2,
      CSR_DATA_BYTE_TYPE    = 3'd3,
      CSR_DATA_REQUEST_TYPE = 3'd4
   } csr_index_type;

   // Fields decoded from the line buffer, passed to the top level.
   typedef struct packed {
      logic [7:0] msg_type;
      logic [7:0] node_id;
      logic [7:0] id_field;
      logic [7:0] payload;
      logic [7:0] parity;
      logic       full;
   } line_fields_type;

   // Converts one ASCII character to a hex digit; anything that is not a
   // hex digit reads as zero. Letters are folded to lower case first.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] low;
      begin
         low = c | 8'h20;
         if (c >= 8'h30 && c <= 8'h39) begin
            return c[3:0];
         end else if (low >= 8'h61 && low <= 8'h66) begin
            return 4'(low[3:0] + 4'd9);
         end else begin
            return 4'd0;
         end
      end
   endfunction

   // Combines two characters into one byte, high digit first.
   function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
      return {hex_nibble(hi), hex_nibble(lo)};
   endfunction

endpackage

`default_nettype wire

// ===== design/hfpp_line_buf.sv =====
// Line buffer of the hex frame parity parser: stores received characters,
// counts them and decodes the fixed hex pairs of the stored line.
// Depends on hfpp_pkg.
`default_nettype none

module hfpp_line_buf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [7:0]               wr_byte,
   output      hfpp_pkg::line_fields_type fields
);

   logic [7:0]                 store_ff [hfpp_pkg::LINE_LENGTH];
   logic [hfpp_pkg::CNT_W-1:0] count_ff;
   logic [hfpp_pkg::CNT_W-1:0] count_in;
   logic                       full_ff;
   logic                       full_in;
   logic                       room;
   logic                       is_lf;
   // Stored characters plus one zero slot past the end for pairs that run over.
   logic [7:0]                 tap [hfpp_pkg::LINE_LENGTH + 1];

   assign room  = (count_ff < hfpp_pkg::CNT_W'(hfpp_pkg::LINE_LENGTH));
   assign is_lf = (wr_byte == hfpp_pkg::LINE_FEED);

   // Count update: saturate at the line length, restart after a line feed.
   always_comb begin
      count_in = count_ff;
      full_in  = full_ff;
      if (wr_en) begin
         if (is_lf) begin
            count_in = '0;
            full_in  = (count_ff >= hfpp_pkg::CNT_W'(hfpp_pkg::LINE_LENGTH - 1));
         end else if (room) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         full_ff  <= full_in;
      end
   end

   // Character store; the line feed itself is stored while there is room.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hfpp_pkg::LINE_LENGTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_en && room) begin
         store_ff[count_ff[hfpp_pkg::IDX_W-1:0]] <= wr_byte;
      end
   end

   always_comb begin
      for (int i = 0; i < hfpp_pkg::LINE_LENGTH; i++) begin
         tap[i] = store_ff[i];
      end
      tap[hfpp_pkg::LINE_LENGTH] = 8'h00;
   end

   // Fixed-position decode of the stored line.
   always_comb begin
      fields.msg_type = hfpp_pkg::hex_pair(tap[hfpp_pkg::POS_TYPE],
                                           tap[hfpp_pkg::POS_TYPE + 1]);
      fields.node_id  = hfpp_pkg::hex_pair(tap[hfpp_pkg::POS_NODE],
                                           tap[hfpp_pkg::POS_NODE + 1]);
      fields.id_field = hfpp_pkg::hex_pair(tap[hfpp_pkg::POS_ID],
                                           tap[hfpp_pkg::POS_ID + 1]);
      fields.payload  = hfpp_pkg::hex_pair(tap[hfpp_pkg::POS_PAYLOAD],
                                           tap[hfpp_pkg::POS_PAYLOAD + 1]);
      fields.parity   = hfpp_pkg::hex_pair(tap[hfpp_pkg::POS_PARITY],
                                           tap[hfpp_pkg::POS_PARITY + 1]);
      fields.full     = full_ff;
   end

endmodule

`default_nettype wire

// ===== design/hex_frame_parity_parser.sv =====
// Hex frame parity parser, top level. Takes one character per cycle while
// no decode waits on a stalled response. A line feed is stored and sets the
// decode-pending flag; the decode of the stored line is registered into the
// response register once the output is free. Reset clears the line store,
// the count, the kept ids and check value and loads the default type codes.
// Depends on hfpp_pkg and hfpp_line_buf.
`default_nettype none

module hex_frame_parity_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_msg_type,
   output      logic [7:0] rsp_node_id,
   output      logic [7:0] rsp_payload,
   output      logic [7:0] rsp_command_id,
   output      logic [7:0] rsp_sensor_id,
   output      logic [7:0] rsp_received_parity,
   output      logic [7:0] rsp_computed_parity,
   output      logic       rsp_accepted,
   input  wire logic       csr_wr_en,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   hfpp_pkg::line_fields_type fields;

   logic [7:0] cmd_code_ff, reply_code_ff, int_code_ff, byte_code_ff, dreq_code_ff;
   logic       dec_valid_ff, dec_valid_in;
   logic [7:0] cmd_id_ff, cmd_id_in;
   logic [7:0] sensor_id_ff, sensor_id_in;
   logic [7:0] check_ff, check_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       advance;
   logic       req_fire;
   logic       lf_fire;
   logic       is_cmd, is_data;
   logic [7:0] new_check;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_code_ff   <= 8'd0;
         reply_code_ff <= 8'd1;
         int_code_ff   <= 8'd2;
         byte_code_ff  <= 8'd3;
         dreq_code_ff  <= 8'd4;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hfpp_pkg::CSR_COMMAND_TYPE:      cmd_code_ff   <= csr_wdata;
            hfpp_pkg::CSR_REPLY_TYPE:        reply_code_ff <= csr_wdata;
            hfpp_pkg::CSR_DATA_INT_TYPE:     int_code_ff   <= csr_wdata;
            hfpp_pkg::CSR_DATA_BYTE_TYPE:    byte_code_ff  <= csr_wdata;
            hfpp_pkg::CSR_DATA_REQUEST_TYPE: dreq_code_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: a pending decode holds off new characters until it can move on.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = dec_valid_ff && out_free;
   assign req_ready = !dec_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;
   assign lf_fire   = req_fire && (req_rx_byte == hfpp_pkg::LINE_FEED);

   hfpp_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire),
      .wr_byte (req_rx_byte),
      .fields  (fields)
   );

   // Type matching and kept-state update; command types take priority.
   assign is_cmd    = (fields.msg_type == cmd_code_ff) || (fields.msg_type == reply_code_ff);
   assign is_data   = (fields.msg_type == int_code_ff) || (fields.msg_type == byte_code_ff) ||
                      (fields.msg_type == dreq_code_ff);
   assign new_check = fields.msg_type ^ fields.node_id ^ fields.id_field ^ fields.payload;

   always_comb begin
      cmd_id_in    = cmd_id_ff;
      sensor_id_in = sensor_id_ff;
      check_in     = check_ff;
      if (advance) begin
         priority if (is_cmd) begin
            cmd_id_in = fields.id_field;
            check_in  = new_check;
         end else if (is_data) begin
            sensor_id_in = fields.id_field;
            check_in     = new_check;
         end
      end
   end

   // Decode-pending flag and response valid.
   always_comb begin
      dec_valid_in = dec_valid_ff;
      if (advance) begin
         dec_valid_in = 1'b0;
      end
      if (lf_fire) begin
         dec_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cmd_id_ff    <= '0;
         sensor_id_ff <= '0;
         check_ff     <= '0;
      end else begin
         dec_valid_ff <= dec_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_id_ff    <= cmd_id_in;
         sensor_id_ff <= sensor_id_in;
         check_ff     <= check_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_msg_type        <= fields.msg_type;
         rsp_node_id         <= fields.node_id;
         rsp_payload         <= fields.payload;
         rsp_command_id      <= cmd_id_in;
         rsp_sensor_id       <= sensor_id_in;
         rsp_received_parity <= fields.parity;
         rsp_computed_parity <= check_in;
         rsp_accepted        <= fields.full && (check_in == fields.parity);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/hfpp_checker.sv =====
// Port-level checker for the hex frame parity parser, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module hfpp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_msg_type,
   input wire logic [7:0] rsp_received_parity,
   input wire logic [7:0] rsp_computed_parity,
   input wire logic       rsp_accepted
);

   // A response that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_msg_type) && $stable(rsp_computed_parity))
      else $error("response changed while stalled");

   // An accepted line always carries matching parities.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_computed_parity == rsp_received_parity)
      else $error("line accepted with mismatched parity");

   // No response is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind hex_frame_parity_parser hfpp_checker u_hfpp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_msg_type        (rsp_msg_type),
   .rsp_received_parity (rsp_received_parity),
   .rsp_computed_parity (rsp_computed_parity),
   .rsp_accepted        (rsp_accepted)
);

`default_nettype wire

// ===== tb/tb_hex_frame_parity_parser.sv =====
// Self-checking testbench for the hex frame parity parser.
// Drives received characters and type code writes, predicts every decoded line
// and compares it with the block's responses. Depends on hfpp_pkg and the RTL.

module tb_hex_frame_parity_parser;
   timeunit 1ns;
   timeprecision 1ps;

   // Number of type code registers; indexes above the last one are ignored.
   localparam int CODE_COUNT = int'(hfpp_pkg::CSR_DATA_REQUEST_TYPE) + 1;
   localparam int INDEX_SPAN = 2 ** $bits(hfpp_pkg::csr_index_type);

   // Letter case used when spelling hex digits.
   localparam int LOWER_CASE = 0;
   localparam int UPPER_CASE = 1;
   localparam int MIXED_CASE = 2;

   // Receiver hold-off used to back the block up.
   localparam int LONG_HOLD_CYCLES = 300;
   // Quiet cycles after the last response before the block counts as idle.
   localparam int SETTLE_CYCLES = 8;
   // Idle chance of either side, in percent.
   localparam int IDLE_PERCENT = 11;

   // One decoded line as the block reports it.
   typedef struct packed {
      logic [7:0] msg_type;
      logic [7:0] node_id;
      logic [7:0] payload;
      logic [7:0] command_id;
      logic [7:0] sensor_id;
      logic [7:0] received_parity;
      logic [7:0] computed_parity;
      logic       accepted;
   } line_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_msg_type;
   logic [7:0] rsp_node_id;
   logic [7:0] rsp_payload;
   logic [7:0] rsp_command_id;
   logic [7:0] rsp_sensor_id;
   logic [7:0] rsp_received_parity;
   logic [7:0] rsp_computed_parity;
   logic       rsp_accepted;
   logic       csr_wr_en = 1'b0;
   logic [2:0] csr_index = 3'b000;
   logic [7:0] csr_wdata = 8'h00;

   // Characters waiting to be offered, and decoded lines waiting to come back.
   logic [7:0]      tx_chars [$];
   line_result_type pending_results [$];

   // Shadow copy of the parser state and its type codes.
   logic [7:0] shadow_line [hfpp_pkg::LINE_LENGTH];
   int         shadow_count;
   logic [7:0] shadow_command_id;
   logic [7:0] shadow_sensor_id;
   logic [7:0] shadow_check;
   logic [7:0] shadow_codes [CODE_COUNT];

   // Traffic shaping and bookkeeping.
   bit calm = 1'b0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int chars_queued = 0;
   int chars_sent = 0;
   int lines_sent = 0;
   int results_checked = 0;
   int accepted_seen = 0;
   int reg_writes = 0;
   int mismatches = 0;

   hex_frame_parity_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_msg_type        (rsp_msg_type),
      .rsp_node_id         (rsp_node_id),
      .rsp_payload         (rsp_payload),
      .rsp_command_id      (rsp_command_id),
      .rsp_sensor_id       (rsp_sensor_id),
      .rsp_received_parity (rsp_received_parity),
      .rsp_computed_parity (rsp_computed_parity),
      .rsp_accepted        (rsp_accepted),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #10 clock = ~clock;

   // Value of one hex digit character; anything else counts as zero.
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c >= "0" && c <= "9") begin
         return 4'(c - "0");
      end
      if (folded >= "a" && folded <= "f") begin
         return 4'(folded - "a" + 8'd10);
      end
      return 4'd0;
   endfunction

   // Byte spelled by the digit pair that starts at pos in the shadow line.
   function automatic logic [7:0] shadow_pair(input int pos);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = (pos < hfpp_pkg::LINE_LENGTH) ? digit_value(shadow_line[pos]) : 4'd0;
      lo = (pos + 1 < hfpp_pkg::LINE_LENGTH) ? digit_value(shadow_line[pos + 1]) : 4'd0;
      return {hi, lo};
   endfunction

   function automatic logic [7:0] line_check(input logic [7:0] t, n, i, p);
      return t ^ n ^ i ^ p;
   endfunction

   // Advances the shadow parser by one character. Returns 1 and the decoded
   // line when the character is a line feed.
   function automatic bit decode_char(input logic [7:0] c, output line_result_type res);
      logic [7:0] f_type;
      logic [7:0] f_node;
      logic [7:0] f_id;
      logic [7:0] f_pay;
      logic [7:0] f_par;
      bit         full;
      res = '0;
      if (shadow_count < hfpp_pkg::LINE_LENGTH) begin
         shadow_line[shadow_count] = c;
         shadow_count++;
      end
      if (c != hfpp_pkg::LINE_FEED) begin
         return 1'b0;
      end
      full = (shadow_count >= hfpp_pkg::LINE_LENGTH);
      shadow_count = 0;
      f_type = shadow_pair(hfpp_pkg::POS_TYPE);
      f_node = shadow_pair(hfpp_pkg::POS_NODE);
      f_id   = shadow_pair(hfpp_pkg::POS_ID);
      f_pay  = shadow_pair(hfpp_pkg::POS_PAYLOAD);
      f_par  = shadow_pair(hfpp_pkg::POS_PARITY);
      // Command types win over data types when the codes collide.
      if (f_type == shadow_codes[hfpp_pkg::CSR_COMMAND_TYPE] ||
          f_type == shadow_codes[hfpp_pkg::CSR_REPLY_TYPE]) begin
         shadow_command_id = f_id;
         shadow_check = line_check(f_type, f_node, f_id, f_pay);
      end else if (f_type == shadow_codes[hfpp_pkg::CSR_DATA_INT_TYPE] ||
                   f_type == shadow_codes[hfpp_pkg::CSR_DATA_BYTE_TYPE] ||
                   f_type == shadow_codes[hfpp_pkg::CSR_DATA_REQUEST_TYPE]) begin
         shadow_sensor_id = f_id;
         shadow_check = line_check(f_type, f_node, f_id, f_pay);
      end
      res.msg_type        = f_type;
      res.node_id         = f_node;
      res.payload         = f_pay;
      res.command_id      = shadow_command_id;
      res.sensor_id       = shadow_sensor_id;
      res.received_parity = f_par;
      res.computed_parity = shadow_check;
      res.accepted        = full && (shadow_check == f_par);
      return 1'b1;
   endfunction

   // Any character except the line feed.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom);
      end while (c == hfpp_pkg::LINE_FEED);
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input int letter_case);
      bit upper;
      upper = (letter_case == MIXED_CASE) ? 1'($urandom_range(0, 1))
                                          : (letter_case == UPPER_CASE);
      if (v < 4'd10) begin
         return 8'("0" + v);
      end
      return 8'((upper ? "A" : "a") + v - 4'd10);
   endfunction

   task automatic queue_char(input logic [7:0] c);
      tx_chars.push_back(c);
      chars_queued++;
   endtask

   // Queues one line: the first keep characters of a full frame, extra
   // characters past the end, then the line feed. Garbling overwrites
   // random positions with arbitrary characters.
   task automatic queue_line(input logic [7:0] f_type, f_node, f_id, f_pay, f_par,
                             input int keep, input int extra, input int garble,
                             input int letter_case);
      logic [7:0] fields [5];
      int         spots [5];
      logic [7:0] text [hfpp_pkg::LINE_LENGTH - 1];
      fields = '{f_type, f_node, f_id, f_pay, f_par};
      spots  = '{hfpp_pkg::POS_TYPE, hfpp_pkg::POS_NODE, hfpp_pkg::POS_ID,
                 hfpp_pkg::POS_PAYLOAD, hfpp_pkg::POS_PARITY};
      for (int k = 0; k < hfpp_pkg::LINE_LENGTH - 1; k++) begin
         text[k] = 8'($urandom_range(32, 126));
      end
      for (int k = 0; k < 5; k++) begin
         text[spots[k]]     = hex_char(fields[k][7:4], letter_case);
         text[spots[k] + 1] = hex_char(fields[k][3:0], letter_case);
      end
      for (int k = 0; k < garble; k++) begin
         text[$urandom_range(0, hfpp_pkg::LINE_LENGTH - 2)] = plain_char();
      end
      for (int k = 0; k < keep; k++) begin
         queue_char(text[k]);
      end
      for (int k = 0; k < extra; k++) begin
         queue_char(plain_char());
      end
      queue_char(hfpp_pkg::LINE_FEED);
   endtask

   // Random traffic: mostly well-formed lines with random content, the rest
   // short, overlong or garbled lines and bursts of raw bytes.
   task automatic queue_random_traffic(input int budget);
      int         stop_at;
      int         kind;
      logic [7:0] t;
      logic [7:0] n;
      logic [7:0] i;
      logic [7:0] p;
      logic [7:0] par;
      stop_at = chars_queued + budget;
      while (chars_queued < stop_at) begin
         kind = $urandom_range(0, 99);
         t = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                         : shadow_codes[$urandom_range(0, CODE_COUNT - 1)];
         n = 8'($urandom);
         i = 8'($urandom);
         p = 8'($urandom);
         par = ($urandom_range(0, 99) < 85) ? line_check(t, n, i, p) : 8'($urandom);
         if (kind < 70) begin
            queue_line(t, n, i, p, par, hfpp_pkg::LINE_LENGTH - 1, 0, 0, MIXED_CASE);
         end else if (kind < 80) begin
            queue_line(t, n, i, p, par, $urandom_range(0, hfpp_pkg::LINE_LENGTH - 2), 0, 0,
                       MIXED_CASE);
         end else if (kind < 88) begin
            queue_line(t, n, i, p, par, hfpp_pkg::LINE_LENGTH - 1, $urandom_range(1, 20), 0,
                       MIXED_CASE);
         end else if (kind < 95) begin
            queue_line(t, n, i, p, par, hfpp_pkg::LINE_LENGTH - 1, 0, $urandom_range(1, 3),
                       MIXED_CASE);
         end else begin
            repeat ($urandom_range(1, 20)) queue_char(8'($urandom));
         end
      end
   endtask

   // One register write; the shadow codes follow at once since the block is idle.
   task automatic write_reg(input int idx, input logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= 3'(idx);
      csr_wdata <= value;
      if (idx < CODE_COUNT) begin
         shadow_codes[idx] = value;
      end
      reg_writes++;
   endtask

   // Writes all five type codes, then pokes the unused indexes with junk.
   task automatic set_codes(input logic [7:0] c_cmd, c_reply, c_int, c_byte, c_req);
      write_reg(hfpp_pkg::CSR_COMMAND_TYPE, c_cmd);
      write_reg(hfpp_pkg::CSR_REPLY_TYPE, c_reply);
      write_reg(hfpp_pkg::CSR_DATA_INT_TYPE, c_int);
      write_reg(hfpp_pkg::CSR_DATA_BYTE_TYPE, c_byte);
      write_reg(hfpp_pkg::CSR_DATA_REQUEST_TYPE, c_req);
      for (int idx = CODE_COUNT; idx < INDEX_SPAN; idx++) begin
         write_reg(idx, 8'($urandom));
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every queued request is taken and every decoded line is
   // back, then lets the block settle. Sampled on the falling edge so that
   // the driver's work at the rising edge is complete.
   task automatic wait_idle();
      while (tx_chars.size() != 0 || req_valid || pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Line %0d: %s expected %02h, got %02h", results_checked, name, want, got);
         end
      end
   endtask

   // Request driver: offers queued characters, holding each until taken,
   // and predicts the outcome of every accepted one.
   always @(posedge clock) begin
      line_result_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            chars_sent++;
            if (decode_char(req_rx_byte, res)) begin
               pending_results.push_back(res);
               lines_sent++;
            end
         end
         if (!req_valid || req_ready) begin
            if (tx_chars.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_valid   <= 1'b1;
               req_rx_byte <= tx_chars.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_left   <= 0;
         hold_served <= 0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Response monitor: compares each decoded line with the oldest prediction.
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Line %0d: response with no prediction waiting", results_checked);
            end
         end else begin
            want = pending_results.pop_front();
            check_field("msg_type", want.msg_type, rsp_msg_type);
            check_field("node_id", want.node_id, rsp_node_id);
            check_field("payload", want.payload, rsp_payload);
            check_field("command_id", want.command_id, rsp_command_id);
            check_field("sensor_id", want.sensor_id, rsp_sensor_id);
            check_field("received_parity", want.received_parity, rsp_received_parity);
            check_field("computed_parity", want.computed_parity, rsp_computed_parity);
            check_field("accepted", {7'd0, want.accepted}, {7'd0, rsp_accepted});
            if (rsp_accepted === 1'b1) begin
               accepted_seen++;
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      logic [7:0] kept;
      // Shadow state after reset.
      for (int k = 0; k < hfpp_pkg::LINE_LENGTH; k++) begin
         shadow_line[k] = 8'h00;
      end
      shadow_count      = 0;
      shadow_command_id = 8'h00;
      shadow_sensor_id  = 8'h00;
      shadow_check      = 8'h00;
      for (int k = 0; k < CODE_COUNT; k++) begin
         shadow_codes[k] = 8'(k);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed lines with the default codes. A bare line feed first reads
      // the cleared store.
      queue_char(hfpp_pkg::LINE_FEED);
      queue_line(8'h00, 8'hFF, 8'h5A, 8'hA5, line_check(8'h00, 8'hFF, 8'h5A, 8'hA5),
                 hfpp_pkg::LINE_LENGTH - 1, 0, 0, UPPER_CASE);
      queue_line(8'h01, 8'h3C, 8'hC3, 8'h0F, line_check(8'h01, 8'h3C, 8'hC3, 8'h0F),
                 hfpp_pkg::LINE_LENGTH - 1, 0, 0, LOWER_CASE);
      queue_line(8'h02, 8'h80, 8'h7F, 8'hFF, line_check(8'h02, 8'h80, 8'h7F, 8'hFF),
                 hfpp_pkg::LINE_LENGTH - 1, 0, 0, MIXED_CASE);
      queue_line(8'h03, 8'h01, 8'hFE, 8'h00, line_check(8'h03, 8'h01, 8'hFE, 8'h00),
                 hfpp_pkg::LINE_LENGTH - 1, 0, 0, MIXED_CASE);
      kept = line_check(8'h04, 8'h12, 8'hEF, 8'h9B);
      queue_line(8'h04, 8'h12, 8'hEF, 8'h9B, kept, hfpp_pkg::LINE_LENGTH - 1, 0, 0,
                 UPPER_CASE);
      // Unknown type keeps the previous check value, so this parity matches.
      queue_line(8'h7E, 8'h00, 8'hFF, 8'h00, kept, hfpp_pkg::LINE_LENGTH - 1, 0, 0,
                 MIXED_CASE);
      // Unknown type with all-ones fields.
      queue_line(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, hfpp_pkg::LINE_LENGTH - 1, 0, 0,
                 UPPER_CASE);
      // Wrong parity on a command.
      queue_line(8'h00, 8'h11, 8'h22, 8'h33, line_check(8'h00, 8'h11, 8'h22, 8'h34),
                 hfpp_pkg::LINE_LENGTH - 1, 0, 0, MIXED_CASE);
      // Overlong line, and one exactly a character too long.
      queue_line(8'h01, 8'hAB, 8'hCD, 8'hEF, line_check(8'h01, 8'hAB, 8'hCD, 8'hEF),
                 hfpp_pkg::LINE_LENGTH - 1, 12, 0, MIXED_CASE);
      queue_line(8'h02, 8'h55, 8'hAA, 8'h5A, line_check(8'h02, 8'h55, 8'hAA, 8'h5A),
                 hfpp_pkg::LINE_LENGTH - 1, 1, 0, LOWER_CASE);
      // Short line: the tail still holds the previous line's characters.
      queue_line(8'h03, 8'h44, 8'h99, 8'hDE, line_check(8'h03, 8'h44, 8'h99, 8'hDE),
                 7, 0, 0, MIXED_CASE);
      // Non-hex characters in the digit positions.
      queue_line(8'h04, 8'h21, 8'h43, 8'h65, line_check(8'h04, 8'h21, 8'h43, 8'h65),
                 hfpp_pkg::LINE_LENGTH - 1, 0, 4, MIXED_CASE);
      // Raw byte extremes followed by a line feed.
      queue_char(8'h00);
      queue_char(8'hFF);
      queue_char(hfpp_pkg::LINE_FEED);
      wait_idle();

      // All codes zero: every data code collides with the command code.
      set_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_random_traffic(150);
      wait_idle();

      // All codes at the top of the range.
      set_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_line(8'hFF, 8'h00, 8'h81, 8'h7E, line_check(8'hFF, 8'h00, 8'h81, 8'h7E),
                 hfpp_pkg::LINE_LENGTH - 1, 0, 0, MIXED_CASE);
      queue_random_traffic(150);
      wait_idle();

      // A stretch with no idling on either side.
      set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      calm = 1'b1;
      queue_random_traffic(250);
      wait_idle();
      calm = 1'b0;

      // Long receiver hold-off while well-formed lines keep coming.
      set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      hold_requests++;
      repeat (12) begin
         queue_line(shadow_codes[hfpp_pkg::CSR_DATA_INT_TYPE], 8'h10, 8'h20, 8'h30,
                    line_check(shadow_codes[hfpp_pkg::CSR_DATA_INT_TYPE], 8'h10, 8'h20, 8'h30),
                    hfpp_pkg::LINE_LENGTH - 1, 0, 0, MIXED_CASE);
      end
      queue_random_traffic(50);
      wait_idle();

      // Two more random settings.
      repeat (2) begin
         set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         queue_random_traffic(125);
         wait_idle();
      end

      $display("Sent %0d characters making %0d lines, %0d of them accepted,",
               chars_sent, lines_sent, accepted_seen);
      $display("over %0d register writes, with short, overlong and garbled lines,", reg_writes);
      $display("code collisions and a long response hold.");
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
